// ----- rtl/nmdf_pkg.sv -----
// Shared types and constants of the duplicate filter.
`timescale 1ns / 1ps

package nmdf_pkg;

   localparam int NODE_W   = 32;
   localparam int TIME_W   = 62;
   localparam int TOPIC_W  = 32;
   localparam int COUNT_W  = 32;
   localparam int VERD_W   = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 62;

   localparam logic [TIME_W-1:0] WINDOW_RESET = 62'd5000000000;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_NODE      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESYNC_WINDOW = 1'd1;

   localparam logic [VERD_W-1:0] VERD_OWN    = 3'd0;
   localparam logic [VERD_W-1:0] VERD_BADSUM = 3'd1;
   localparam logic [VERD_W-1:0] VERD_DUP    = 3'd2;
   localparam logic [VERD_W-1:0] VERD_REPORT = 3'd3;
   localparam logic [VERD_W-1:0] VERD_DATA   = 3'd4;
   localparam logic [VERD_W-1:0] VERD_NEG    = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_AGE
   } flt_state_type;

endpackage

// ----- rtl/network_message_duplicate_filter_core.sv -----
// Top level of the per-sender timestamp replay filter.
`timescale 1ns / 1ps

// Usage:
// An item (message header) is taken on a clock edge with start high and busy low.
// busy stays high while the sender table is searched. Each item gives exactly one
// result, shown on the rsp_ ports for one cycle while rsp_valid is high; the
// receiver must take it then.
// An own-node or bad-checksum item is answered in the cycle after it is taken.
// Otherwise the table is scanned one entry a cycle through the table memory's
// single read port. The scan stops at the first entry that holds the sender,
// whose stored timestamp is then judged; a new sender is answered once all
// used entries (up to MAX_SENDERS) are read. A single 62-bit subtract and
// compare judges the timestamp age.
// busy falls in the cycle the result is shown, so the next item may be taken then.
// csr_ writes (own node, resync window) take effect at once; make them only while idle.
// Reset (synchronous, active high) empties the table, clears the accepted
// count and own node, and restores the default window of 5e9 time units.
module network_message_duplicate_filter_core #(
   parameter int MAX_SENDERS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [nmdf_pkg::NODE_W-1:0]      req_sender_node,
   input  logic        [nmdf_pkg::TIME_W-1:0]      req_sent_time,
   input  logic signed [nmdf_pkg::TOPIC_W-1:0]     req_topic,
   input  logic                                    req_checksum_ok,
   output logic                                    rsp_valid,
   output logic        [nmdf_pkg::VERD_W-1:0]      rsp_verdict,
   output logic                                    rsp_table_full,
   output logic        [nmdf_pkg::COUNT_W-1:0]     rsp_accepted_count,
   input  logic                                    csr_write_en,
   input  logic        [nmdf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [nmdf_pkg::CSR_DAT_W-1:0]   csr_write_data
);

   localparam int CNT_W = $clog2(MAX_SENDERS + 1);
   localparam int IDX_W = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;
   localparam logic [CNT_W-1:0] USED_MAX = CNT_W'(MAX_SENDERS);

   localparam int NW = nmdf_pkg::NODE_W;
   localparam int TW = nmdf_pkg::TIME_W;

   logic [NW-1:0] ids_mem   [MAX_SENDERS];
   logic [TW-1:0] times_mem [MAX_SENDERS];

   nmdf_pkg::flt_state_type state_ff, state_in;

   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pidx_ff;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [NW-1:0]      rd_id_ff;
   logic [TW-1:0]      rd_time_ff;
   logic [NW-1:0]      who_ff;
   logic [TW-1:0]      when_ff;
   logic               topic_neg_ff, topic_zero_ff;
   logic [nmdf_pkg::COUNT_W-1:0] total_ff, total_in;
   logic [NW-1:0]      own_ff;
   logic [TW-1:0]      window_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [nmdf_pkg::VERD_W-1:0]  rsp_verdict_ff, rsp_verdict_in;
   logic                         rsp_full_ff, rsp_full_in;
   logic [nmdf_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               take;
   logic               issue;
   logic               hit;
   logic               rd_en;
   logic               id_we, time_we;
   logic [IDX_W-1:0]   wr_addr;
   logic [TW:0]        age;
   logic               older_ok;
   logic [nmdf_pkg::VERD_W-1:0] acc_verdict;

   assign take    = start && (state_ff == nmdf_pkg::ST_IDLE);
   assign issue   = (scan_ff < used_ff);
   assign hit     = pend_ff && (rd_id_ff == who_ff);
   assign rd_en   = (state_ff == nmdf_pkg::ST_SCAN) && !hit && issue;

   // shared age unit: stored minus new, borrow means the new one is newer
   assign age      = {1'b0, rd_time_ff} - {1'b0, when_ff};
   assign older_ok = !age[TW] && (age[TW-1:0] <= window_ff);

   always_comb begin
      if (topic_zero_ff) begin
         acc_verdict = nmdf_pkg::VERD_REPORT;
      end else if (topic_neg_ff) begin
         acc_verdict = nmdf_pkg::VERD_NEG;
      end else begin
         acc_verdict = nmdf_pkg::VERD_DATA;
      end
   end

   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      used_in        = used_ff;
      pend_in        = pend_ff;
      hit_idx_in     = hit_idx_ff;
      total_in       = total_ff;
      rsp_valid_in   = 1'b0;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_count_in   = rsp_count_ff;
      id_we          = 1'b0;
      time_we        = 1'b0;
      wr_addr        = hit_idx_ff;
      unique case (state_ff)
         nmdf_pkg::ST_IDLE: begin
            if (take) begin
               if (req_sender_node == own_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_verdict_in = nmdf_pkg::VERD_OWN;
                  rsp_full_in    = 1'b0;
                  rsp_count_in   = total_ff;
               end else if (!req_checksum_ok) begin
                  rsp_valid_in   = 1'b1;
                  rsp_verdict_in = nmdf_pkg::VERD_BADSUM;
                  rsp_full_in    = 1'b0;
                  rsp_count_in   = total_ff;
               end else begin
                  state_in = nmdf_pkg::ST_SCAN;
                  scan_in  = '0;
                  pend_in  = 1'b0;
               end
            end
         end
         nmdf_pkg::ST_SCAN: begin
            if (hit) begin
               hit_idx_in = pidx_ff;
               state_in   = nmdf_pkg::ST_AGE;
            end else if (!pend_ff && !issue) begin
               // new sender
               total_in       = total_ff + 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = acc_verdict;
               rsp_count_in   = total_ff + 1'b1;
               state_in       = nmdf_pkg::ST_IDLE;
               if (used_ff >= USED_MAX) begin
                  rsp_full_in = 1'b1;
               end else begin
                  rsp_full_in = 1'b0;
                  id_we       = 1'b1;
                  time_we     = 1'b1;
                  wr_addr     = used_ff[IDX_W-1:0];
                  used_in     = used_ff + 1'b1;
               end
            end else begin
               pend_in = issue;
               if (issue) begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         nmdf_pkg::ST_AGE: begin
            rsp_valid_in = 1'b1;
            rsp_full_in  = 1'b0;
            state_in     = nmdf_pkg::ST_IDLE;
            if (older_ok) begin
               rsp_verdict_in = nmdf_pkg::VERD_DUP;
               rsp_count_in   = total_ff;
            end else begin
               time_we        = 1'b1;
               total_in       = total_ff + 1'b1;
               rsp_verdict_in = acc_verdict;
               rsp_count_in   = total_ff + 1'b1;
            end
         end
         default: begin
            state_in = nmdf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nmdf_pkg::ST_IDLE;
         used_ff      <= '0;
         total_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         own_ff       <= '0;
         window_ff    <= nmdf_pkg::WINDOW_RESET;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               nmdf_pkg::CSR_OWN_NODE:      own_ff    <= csr_write_data[NW-1:0];
               nmdf_pkg::CSR_RESYNC_WINDOW: window_ff <= csr_write_data[TW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff        <= scan_in;
      hit_idx_ff     <= hit_idx_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_count_ff   <= rsp_count_in;
      if (rd_en) begin
         pidx_ff <= scan_ff[IDX_W-1:0];
      end
      if (take) begin
         who_ff        <= req_sender_node;
         when_ff       <= req_sent_time;
         topic_zero_ff <= (req_topic == '0);
         topic_neg_ff  <= req_topic[nmdf_pkg::TOPIC_W-1];
      end
   end

   // sender table
   always_ff @(posedge clock) begin
      if (id_we) begin
         ids_mem[wr_addr] <= who_ff;
      end
      if (time_we) begin
         times_mem[wr_addr] <= when_ff;
      end
      if (rd_en) begin
         rd_id_ff   <= ids_mem[scan_ff[IDX_W-1:0]];
         rd_time_ff <= times_mem[scan_ff[IDX_W-1:0]];
      end
   end

   assign busy               = (state_ff != nmdf_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = rsp_verdict_ff;
   assign rsp_table_full     = rsp_full_ff;
   assign rsp_accepted_count = rsp_count_ff;

endmodule

// ----- rtl/nmdf_checker.sv -----
// Port-level checks of the duplicate filter and their binding.
`timescale 1ns / 1ps

module nmdf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [nmdf_pkg::VERD_W-1:0]        rsp_verdict,
   input logic                               rsp_table_full
);

   a_rsp_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_take_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("item taken but neither busy nor answered");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict <= nmdf_pkg::VERD_NEG))
      else $error("verdict code out of range");

   a_full_accepted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |->
         (rsp_verdict == nmdf_pkg::VERD_REPORT || rsp_verdict == nmdf_pkg::VERD_DATA ||
          rsp_verdict == nmdf_pkg::VERD_NEG))
      else $error("table full flagged on a rejected item");

endmodule

bind network_message_duplicate_filter_core nmdf_checker u_nmdf_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_verdict    (rsp_verdict),
   .rsp_table_full (rsp_table_full)
);
